// ===== rtl/pbd_pkg.sv =====
// shared types and constants for the proximity brake decider
package pbd_pkg;

	localparam int unsigned DistW  = 16;
	localparam int unsigned SqW    = 32;
	localparam int unsigned TimeW  = 32;
	localparam int unsigned CountW = 16;
	localparam int unsigned RunW   = 8;
	localparam int unsigned TallyW = 32;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [DistW-1:0] EmergencyRst = 16'd2000;
	localparam logic [DistW-1:0] DangerRst    = 16'd2500;
	localparam logic [DistW-1:0] CautionRst   = 16'd5000;
	localparam logic [RunW-1:0]  QualRunRst   = 8'd3;
	localparam logic [DistW-1:0] TimeoutRst   = 16'd500;

	localparam logic [SqW-1:0] EmergencySqRst = SqW'(32'd2000 * 32'd2000);
	localparam logic [SqW-1:0] DangerSqRst    = SqW'(32'd2500 * 32'd2500);
	localparam logic [SqW-1:0] CautionSqRst   = SqW'(32'd5000 * 32'd5000);

	localparam logic [SqW-1:0]    NoDist   = '1;
	localparam logic [CountW-1:0] CountMax = '1;
	localparam logic [RunW-1:0]   RunMax   = '1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_EMERGENCY  = 3'd0,
		REG_DANGER     = 3'd1,
		REG_CAUTION    = 3'd2,
		REG_QUAL_RUN   = 3'd3,
		REG_TIMEOUT    = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		WARN_NONE      = 2'd0,
		WARN_CAUTION   = 2'd1,
		WARN_DANGER    = 2'd2,
		WARN_EMERGENCY = 2'd3
	} warn_t;

	// thresholds as seen by the datapath, squares kept ready
	typedef struct packed {
		logic [SqW-1:0]   emergency_sq;
		logic [SqW-1:0]   danger_sq;
		logic [SqW-1:0]   caution_sq;
		logic [RunW-1:0]  qual_run;
		logic [DistW-1:0] timeout_ms;
	} thr_t;

	typedef struct packed {
		logic                    point_valid;
		logic                    last_in_frame;
		logic signed [DistW-1:0] pos_x;
		logic signed [DistW-1:0] pos_y;
		logic [TimeW-1:0]        frame_time_ms;
		logic [SqW-1:0]          dist_sq;
	} pt_t;

	typedef struct packed {
		logic [SqW-1:0]          dist_sq;
		logic signed [DistW-1:0] x;
		logic signed [DistW-1:0] y;
		logic [CountW-1:0]       count;
		logic [TimeW-1:0]        frame_time_ms;
	} frame_t;

endpackage

// ===== rtl/pbd_if.sv =====
// channel interfaces: obstacle points, decisions, register writes
interface pbd_point_if;
	logic               valid;
	logic               ready;
	logic               point_valid;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic               last_in_frame;
	logic [31:0]        frame_time_ms;

	modport source (output valid, point_valid, pos_x, pos_y, last_in_frame, frame_time_ms,
		input ready);
	modport sink (input valid, point_valid, pos_x, pos_y, last_in_frame, frame_time_ms,
		output ready);
endinterface

interface pbd_result_if;
	logic               valid;
	logic               ready;
	logic [31:0]        nearest_dist_sq;
	logic signed [15:0] nearest_x;
	logic signed [15:0] nearest_y;
	logic [15:0]        obstacle_total;
	logic               obstacle_seen;
	logic [1:0]         warn_level;
	logic               brake_now;
	logic [31:0]        decision_tally;
	logic [31:0]        brake_tally;
	logic [31:0]        false_alarm_tally;

	modport source (output valid, nearest_dist_sq, nearest_x, nearest_y, obstacle_total,
		obstacle_seen, warn_level, brake_now, decision_tally, brake_tally,
		false_alarm_tally, input ready);
	modport sink (input valid, nearest_dist_sq, nearest_x, nearest_y, obstacle_total,
		obstacle_seen, warn_level, brake_now, decision_tally, brake_tally,
		false_alarm_tally, output ready);
endinterface

interface pbd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pbd_dist.sv =====
// input register and squared distance stage
module pbd_dist (
	input  logic          clk,
	input  logic          arst_n,
	pbd_point_if.sink     point,
	output logic          s2_valid,
	input  logic          s2_ready,
	output pbd_pkg::pt_t  s2_pt
);

	logic                            s1_v_s1;
	logic                            point_valid_s1;
	logic                            last_s1;
	logic signed [pbd_pkg::DistW-1:0] x_s1;
	logic signed [pbd_pkg::DistW-1:0] y_s1;
	logic [pbd_pkg::TimeW-1:0]       time_s1;
	logic                            s2_v_s2;
	pbd_pkg::pt_t                    pt_s2;

	logic                            s1_free;
	logic                            s2_free;
	logic signed [pbd_pkg::SqW-1:0]  xx;
	logic signed [pbd_pkg::SqW-1:0]  yy;
	logic [pbd_pkg::SqW-1:0]         d2;

	assign s2_free = !s2_v_s2 || s2_ready;
	assign s1_free = !s1_v_s1 || s2_free;
	assign point.ready = s1_free;

	// squares are nonnegative and at most 2^30 each, so the sum fits unsigned
	assign xx = pbd_pkg::SqW'(x_s1) * pbd_pkg::SqW'(x_s1);
	assign yy = pbd_pkg::SqW'(y_s1) * pbd_pkg::SqW'(y_s1);
	assign d2 = $unsigned(xx) + $unsigned(yy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
			s2_v_s2 <= 1'b0;
		end else begin
			if (point.valid && s1_free)
				s1_v_s1 <= 1'b1;
			else if (s2_free)
				s1_v_s1 <= 1'b0;
			if (s2_free)
				s2_v_s2 <= s1_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (point.valid && s1_free) begin
			point_valid_s1 <= point.point_valid;
			last_s1        <= point.last_in_frame;
			x_s1           <= point.pos_x;
			y_s1           <= point.pos_y;
			time_s1        <= point.frame_time_ms;
		end
		if (s1_v_s1 && s2_free) begin
			pt_s2.point_valid   <= point_valid_s1;
			pt_s2.last_in_frame <= last_s1;
			pt_s2.pos_x         <= x_s1;
			pt_s2.pos_y         <= y_s1;
			pt_s2.frame_time_ms <= time_s1;
			pt_s2.dist_sq       <= d2;
		end
	end

	assign s2_valid = s2_v_s2;
	assign s2_pt    = pt_s2;

endmodule

// ===== rtl/pbd_nearest.sv =====
// running nearest point and count over one frame, frame summary register
module pbd_nearest (
	input  logic            clk,
	input  logic            arst_n,
	input  pbd_pkg::thr_t   thr,
	input  logic            s2_valid,
	output logic            s2_ready,
	input  pbd_pkg::pt_t    s2_pt,
	output logic            s3_valid,
	input  logic            s3_ready,
	output pbd_pkg::frame_t s3_frame
);

	logic [pbd_pkg::SqW-1:0]          best_dist_q;
	logic signed [pbd_pkg::DistW-1:0] best_x_q;
	logic signed [pbd_pkg::DistW-1:0] best_y_q;
	logic [pbd_pkg::CountW-1:0]       count_q;
	logic                             s3_v_s3;
	pbd_pkg::frame_t                  frame_s3;

	logic            s3_free;
	logic            take;
	logic            counted;
	logic            closer;
	pbd_pkg::frame_t nxt;

	assign s3_free  = !s3_v_s3 || s3_ready;
	assign s2_ready = !s2_pt.last_in_frame || s3_free;
	assign take     = s2_valid && s2_ready;

	// radius is inclusive, ties keep the earlier point
	assign counted = s2_pt.point_valid && (s2_pt.dist_sq <= thr.caution_sq);
	assign closer  = counted && (s2_pt.dist_sq < best_dist_q);

	always_comb begin
		nxt.dist_sq       = closer ? s2_pt.dist_sq : best_dist_q;
		nxt.x             = closer ? s2_pt.pos_x : best_x_q;
		nxt.y             = closer ? s2_pt.pos_y : best_y_q;
		nxt.count         = (counted && count_q != pbd_pkg::CountMax) ?
			count_q + 1'b1 : count_q;
		nxt.frame_time_ms = s2_pt.frame_time_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q <= pbd_pkg::NoDist;
			best_x_q    <= '0;
			best_y_q    <= '0;
			count_q     <= '0;
			s3_v_s3     <= 1'b0;
		end else begin
			if (take) begin
				if (s2_pt.last_in_frame) begin
					best_dist_q <= pbd_pkg::NoDist;
					best_x_q    <= '0;
					best_y_q    <= '0;
					count_q     <= '0;
				end else begin
					best_dist_q <= nxt.dist_sq;
					best_x_q    <= nxt.x;
					best_y_q    <= nxt.y;
					count_q     <= nxt.count;
				end
			end
			if (take && s2_pt.last_in_frame)
				s3_v_s3 <= 1'b1;
			else if (s3_ready)
				s3_v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && s2_pt.last_in_frame)
			frame_s3 <= nxt;
	end

	assign s3_valid = s3_v_s3;
	assign s3_frame = frame_s3;

endmodule

// ===== rtl/pbd_decide.sv =====
// warning level, brake decision, tallies and result register
module pbd_decide (
	input  logic            clk,
	input  logic            arst_n,
	input  pbd_pkg::thr_t   thr,
	input  logic            s3_valid,
	output logic            s3_ready,
	input  pbd_pkg::frame_t s3_frame,
	pbd_result_if.source    result
);

	logic [pbd_pkg::RunW-1:0]   warn_run_q;
	logic [pbd_pkg::TimeW-1:0]  last_warn_q;
	logic                       warn_set_q;
	logic                       prev_brake_q;
	logic [pbd_pkg::TallyW-1:0] decisions_q;
	logic [pbd_pkg::TallyW-1:0] brakes_q;
	logic [pbd_pkg::TallyW-1:0] fa_count_q;
	logic                       out_v_q;
	pbd_pkg::frame_t            out_frame_q;
	pbd_pkg::warn_t             out_level_q;
	logic                       out_brake_q;

	logic                       load;
	pbd_pkg::warn_t             level;
	logic [pbd_pkg::TimeW-1:0]  gap;
	logic                       timed_out;
	logic [pbd_pkg::RunW-1:0]   run_mid;
	logic [pbd_pkg::RunW-1:0]   run_nxt;
	logic                       hot;
	logic                       brake;
	logic                       false_alarm;

	assign s3_ready = !out_v_q || result.ready;
	assign load     = s3_valid && s3_ready;

	always_comb begin
		priority if (s3_frame.dist_sq < thr.emergency_sq)
			level = pbd_pkg::WARN_EMERGENCY;
		else if (s3_frame.dist_sq < thr.danger_sq)
			level = pbd_pkg::WARN_DANGER;
		else if (s3_frame.dist_sq < thr.caution_sq)
			level = pbd_pkg::WARN_CAUTION;
		else
			level = pbd_pkg::WARN_NONE;
	end

	// gap read as signed, so a clock that steps back never clears the run
	assign gap       = s3_frame.frame_time_ms - last_warn_q;
	assign timed_out = warn_set_q && !gap[pbd_pkg::TimeW-1] &&
		(gap[pbd_pkg::TimeW-2:0] > (pbd_pkg::TimeW-1)'(thr.timeout_ms));
	assign run_mid   = timed_out ? '0 : warn_run_q;
	assign hot       = (level == pbd_pkg::WARN_DANGER) || (level == pbd_pkg::WARN_EMERGENCY);

	always_comb begin
		if (!hot)
			run_nxt = '0;
		else if (run_mid == pbd_pkg::RunMax)
			run_nxt = run_mid;
		else
			run_nxt = run_mid + 1'b1;
	end

	assign brake = (level == pbd_pkg::WARN_EMERGENCY) ||
		((level == pbd_pkg::WARN_DANGER) && (run_nxt >= thr.qual_run));
	assign false_alarm = prev_brake_q && !brake && (warn_run_q >= thr.qual_run);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_run_q     <= '0;
			last_warn_q    <= '0;
			warn_set_q     <= 1'b0;
			prev_brake_q   <= 1'b0;
			decisions_q    <= '0;
			brakes_q       <= '0;
			fa_count_q     <= '0;
			out_v_q        <= 1'b0;
		end else begin
			if (load) begin
				warn_run_q   <= run_nxt;
				prev_brake_q <= brake;
				decisions_q  <= decisions_q + 1'b1;
				if (hot) begin
					last_warn_q <= s3_frame.frame_time_ms;
					warn_set_q  <= 1'b1;
				end
				if (brake)
					brakes_q <= brakes_q + 1'b1;
				if (false_alarm)
					fa_count_q <= fa_count_q + 1'b1;
			end
			if (load)
				out_v_q <= 1'b1;
			else if (result.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_frame_q <= s3_frame;
			out_level_q <= level;
			out_brake_q <= brake;
		end
	end

	assign result.valid             = out_v_q;
	assign result.nearest_dist_sq   = out_frame_q.dist_sq;
	assign result.nearest_x         = out_frame_q.x;
	assign result.nearest_y         = out_frame_q.y;
	assign result.obstacle_total    = out_frame_q.count;
	assign result.obstacle_seen     = (out_frame_q.count != '0);
	assign result.warn_level        = out_level_q;
	assign result.brake_now         = out_brake_q;
	assign result.decision_tally    = decisions_q;
	assign result.brake_tally       = brakes_q;
	assign result.false_alarm_tally = fa_count_q;

`ifndef ASSERT_OFF
	a_emergency_brakes: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && (out_level_q == pbd_pkg::WARN_EMERGENCY) |-> out_brake_q)
		else $error("emergency level without brake");

	a_brake_needs_danger: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_brake_q |->
			(out_level_q == pbd_pkg::WARN_DANGER) || (out_level_q == pbd_pkg::WARN_EMERGENCY))
		else $error("brake below danger level");

	a_one_decision_per_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> decisions_q == $past(decisions_q) + 1'b1)
		else $error("decision tally out of step");

	a_run_cleared_when_calm: assert property (@(posedge clk) disable iff (!arst_n)
		load && !hot |=> warn_run_q == '0)
		else $error("warning run kept after calm frame");
`endif

endmodule

// ===== rtl/proximity_brake_decider.sv =====
// top level: register file and the three stages of the brake decider
//
//  channel  dir  payload                                            accept
//  point    in   point_valid pos_x pos_y last_in_frame frame_time   valid & ready
//  result   out  nearest point, count, level, brake, three tallies  valid & ready
//  cfg      in   index (3 bits), data (16 bits), always ready       valid & ready
//
// one point per cycle unless a held result stalls it: input register, squaring stage, running minimum, decision
// a frame's last point passes the input, squaring and frame summary registers on its way to the result register
// the running-minimum compare and update is the feedback loop that sets the rate
// a held result fills the stages behind it; point ready drops only when all are full
// reset (arst_n) restores the default thresholds and clears every tally and run
// register writes go straight into the threshold registers; the three distance thresholds are squared on the write
module proximity_brake_decider (
	input  logic         clk,
	input  logic         arst_n,
	pbd_point_if.sink    point,
	pbd_result_if.source result,
	pbd_cfg_if.sink      cfg
);

	pbd_pkg::thr_t   thr_q;
	logic            s2_valid;
	logic            s2_ready;
	pbd_pkg::pt_t    s2_pt;
	logic            s3_valid;
	logic            s3_ready;
	pbd_pkg::frame_t s3_frame;
	logic [pbd_pkg::SqW-1:0] data_sq;

	assign cfg.ready = 1'b1;
	assign data_sq   = pbd_pkg::SqW'(cfg.data) * pbd_pkg::SqW'(cfg.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.emergency_sq <= pbd_pkg::EmergencySqRst;
			thr_q.danger_sq    <= pbd_pkg::DangerSqRst;
			thr_q.caution_sq   <= pbd_pkg::CautionSqRst;
			thr_q.qual_run     <= pbd_pkg::QualRunRst;
			thr_q.timeout_ms   <= pbd_pkg::TimeoutRst;
		end else if (cfg.valid && cfg.ready) begin
			unique case (pbd_pkg::cfg_reg_t'(cfg.index))
				pbd_pkg::REG_EMERGENCY: thr_q.emergency_sq <= data_sq;
				pbd_pkg::REG_DANGER:    thr_q.danger_sq    <= data_sq;
				pbd_pkg::REG_CAUTION:   thr_q.caution_sq   <= data_sq;
				pbd_pkg::REG_QUAL_RUN:  thr_q.qual_run     <= cfg.data[pbd_pkg::RunW-1:0];
				pbd_pkg::REG_TIMEOUT:   thr_q.timeout_ms   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	pbd_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.point    (point),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready),
		.s2_pt    (s2_pt)
	);

	pbd_nearest u_nearest (
		.clk      (clk),
		.arst_n   (arst_n),
		.thr      (thr_q),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready),
		.s2_pt    (s2_pt),
		.s3_valid (s3_valid),
		.s3_ready (s3_ready),
		.s3_frame (s3_frame)
	);

	pbd_decide u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.thr      (thr_q),
		.s3_valid (s3_valid),
		.s3_ready (s3_ready),
		.s3_frame (s3_frame),
		.result   (result)
	);

endmodule
